@@ rtl/ocap_pkg.sv @@
// Shared constants and types of the offer crossing block.
package ocap_pkg;

  localparam int unsigned AMOUNT_BITS_DEF = 63;
  localparam int unsigned PRICE_BITS_DEF  = 31;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned OUT_DEPTH       = 2;
  // Price error bound: one part in a hundred
  localparam int unsigned PRICE_PCT       = 100;
  localparam int unsigned PCT_BITS        = $clog2(PRICE_PCT + 1);
  localparam int unsigned ST_W            = 3;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_WHEAT_OOB = 3'd1,
    ST_SHEEP_OOB = 3'd2,
    ST_FAV_SHEEP = 3'd3,
    ST_FAV_WHEAT = 3'd4,
    ST_PRICE_ERR = 3'd5
  } status_e;

  // Classification handed from the front part to the back part
  typedef struct packed {
    logic first_wheat;  // first quotient is the wheat amount
    logic ceil_second;  // second division rounds up
    logic stays;        // wheat side value is the larger
    logic path;         // crossing belongs to a path payment
  } ctl_t;

endpackage

@@ rtl/ocap_fifo.sv @@
// Small first-in first-out queue built from registers.
module ocap_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/ocap_mul.sv @@
// Two-stage amount by price multiplier split into two partial products.
module ocap_mul #(
  parameter int unsigned A = 63,
  parameter int unsigned P = 31
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [A-1:0]   a_i,
  input  logic [P-1:0]   b_i,
  output logic [A+P-1:0] p_o
);

  localparam int unsigned LO = (A + 1) / 2;
  localparam int unsigned HI = A - LO;

  logic [LO+P-1:0] pl_q;
  logic [HI+P-1:0] ph_q;
  logic [A+P-1:0]  p_q;

  // partial products, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= {{P{1'b0}}, a_i[LO-1:0]} * {{LO{1'b0}}, b_i};
      ph_q <= {{P{1'b0}}, a_i[A-1:LO]} * {{HI{1'b0}}, b_i};
      p_q  <= {ph_q, {LO{1'b0}}} + {{HI{1'b0}}, pl_q};
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/ocap_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
module ocap_div #(
  parameter int unsigned A   = 63,
  parameter int unsigned P   = 31,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [A+P-1:0] x_i,
  input  logic [P-1:0]   d_i,
  input  logic           up_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [A-1:0]   q_o,
  output logic           ovf_o,
  output logic [SBW-1:0] sb_o
);

  logic           vld_q [A+1];
  logic [P-1:0]   r_q   [A+1];
  logic [A-1:0]   b_q   [A+1];
  logic [P-1:0]   d_q   [A+1];
  logic           up_q  [A+1];
  logic           ovf_q [A+1];
  logic [SBW-1:0] sb_q  [A+1];

  logic [P:0]     t_w   [A+1];
  logic [P:0]     s_w   [A+1];
  logic           ge_w  [A+1];

  logic           out_vld_q;
  logic [A-1:0]   out_q_q;
  logic           out_ovf_q;
  logic [SBW-1:0] out_sb_q;
  logic           round_w;

  // one trial subtraction per stage
  always_comb begin
    t_w[0]  = '0;
    s_w[0]  = '0;
    ge_w[0] = 1'b0;
    for (int k = 1; k <= A; k++) begin
      t_w[k]  = {r_q[k-1], b_q[k-1][A-1]};
      s_w[k]  = t_w[k] - {1'b0, d_q[k-1]};
      ge_w[k] = (t_w[k] >= {1'b0, d_q[k-1]});
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= A; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= A; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[A];
    end
  end

  // quotient too wide when the top part already reaches the divisor
  // (this also catches a zero divisor)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= x_i[A+P-1:A];
      b_q[0]   <= x_i[A-1:0];
      d_q[0]   <= d_i;
      up_q[0]  <= up_i;
      ovf_q[0] <= (x_i[A+P-1:A] >= d_i);
      sb_q[0]  <= sb_i;
      for (int k = 1; k <= A; k++) begin
        r_q[k]   <= ge_w[k] ? s_w[k][P-1:0] : t_w[k][P-1:0];
        b_q[k]   <= {b_q[k-1][A-2:0], ge_w[k]};
        d_q[k]   <= d_q[k-1];
        up_q[k]  <= up_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        sb_q[k]  <= sb_q[k-1];
      end
    end
  end

  // rounding up on a nonzero remainder
  assign round_w = up_q[A] && (r_q[A] != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q_q   <= b_q[A] + A'(round_w);
      out_ovf_q <= ovf_q[A] || (round_w && (&b_q[A]));
      out_sb_q  <= sb_q[A];
    end
  end

  assign vld_o = out_vld_q;
  assign q_o   = out_q_q;
  assign ovf_o = out_ovf_q;
  assign sb_o  = out_sb_q;

endmodule

@@ rtl/ocap_front.sv @@
// Front part: values both sides of the crossing and picks the division path.
module ocap_front import ocap_pkg::*; #(
  parameter int unsigned A = AMOUNT_BITS_DEF,
  parameter int unsigned P = PRICE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           full_o,
  input  logic [P-1:0]   price_num_i,
  input  logic [P-1:0]   price_den_i,
  input  logic [A-1:0]   max_wheat_send_i,
  input  logic [A-1:0]   max_wheat_receive_i,
  input  logic [A-1:0]   max_sheep_send_i,
  input  logic [A-1:0]   max_sheep_receive_i,
  input  logic           path_payment_i,
  output logic           q_push_o,
  input  logic           q_full_i,
  output logic [A+P-1:0] x1_o,
  output logic [P-1:0]   n_o,
  output logic [P-1:0]   d_o,
  output logic [A-1:0]   lim_w_o,
  output logic [A-1:0]   lim_s_o,
  output ctl_t           ctl_o
);

  logic           fe;
  logic [A+P-1:0] p_ws, p_sr, p_ss, p_wr;

  logic           f1_vld_q, f2_vld_q, f3_vld_q;
  logic [P-1:0]   f1_n_q, f2_n_q, f3_n_q;
  logic [P-1:0]   f1_d_q, f2_d_q, f3_d_q;
  logic [A-1:0]   f1_lw_q, f2_lw_q, f3_lw_q;
  logic [A-1:0]   f1_ls_q, f2_ls_q, f3_ls_q;
  logic           f1_path_q, f2_path_q, f3_path_q;
  logic [A+P-1:0] wval_q, sval_q;
  logic           stays, fw;

  // the whole front holds while its last item waits on a full queue
  assign fe     = !(f3_vld_q && q_full_i);
  assign full_o = !fe;

  // side value products
  ocap_mul #(.A(A), .P(P)) u_mul_ws (
    .clk_i(clk_i), .en_i(fe), .a_i(max_wheat_send_i), .b_i(price_num_i), .p_o(p_ws)
  );
  ocap_mul #(.A(A), .P(P)) u_mul_sr (
    .clk_i(clk_i), .en_i(fe), .a_i(max_sheep_receive_i), .b_i(price_den_i), .p_o(p_sr)
  );
  ocap_mul #(.A(A), .P(P)) u_mul_ss (
    .clk_i(clk_i), .en_i(fe), .a_i(max_sheep_send_i), .b_i(price_den_i), .p_o(p_ss)
  );
  ocap_mul #(.A(A), .P(P)) u_mul_wr (
    .clk_i(clk_i), .en_i(fe), .a_i(max_wheat_receive_i), .b_i(price_num_i), .p_o(p_wr)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (fe) begin
      f1_vld_q <= vld_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  // item context alongside the multipliers; amount limits
  always_ff @(posedge clk_i) begin
    if (fe) begin
      f1_n_q    <= price_num_i;
      f1_d_q    <= price_den_i;
      f1_lw_q   <= (max_wheat_receive_i < max_wheat_send_i) ?
                   max_wheat_receive_i : max_wheat_send_i;
      f1_ls_q   <= (max_sheep_receive_i < max_sheep_send_i) ?
                   max_sheep_receive_i : max_sheep_send_i;
      f1_path_q <= path_payment_i;
      f2_n_q    <= f1_n_q;
      f2_d_q    <= f1_d_q;
      f2_lw_q   <= f1_lw_q;
      f2_ls_q   <= f1_ls_q;
      f2_path_q <= f1_path_q;
      f3_n_q    <= f2_n_q;
      f3_d_q    <= f2_d_q;
      f3_lw_q   <= f2_lw_q;
      f3_ls_q   <= f2_ls_q;
      f3_path_q <= f2_path_q;
      // each side is worth the smaller of its two products
      wval_q    <= (p_ws > p_sr) ? p_sr : p_ws;
      sval_q    <= (p_ss > p_wr) ? p_wr : p_ss;
    end
  end

  // path choice
  assign stays = (wval_q > sval_q);
  assign fw    = stays ? ((f3_n_q > f3_d_q) || f3_path_q) : (f3_n_q > f3_d_q);

  assign q_push_o          = f3_vld_q && !q_full_i;
  assign x1_o              = stays ? sval_q : wval_q;
  assign n_o               = f3_n_q;
  assign d_o               = f3_d_q;
  assign lim_w_o           = f3_lw_q;
  assign lim_s_o           = f3_ls_q;
  assign ctl_o.first_wheat = fw;
  assign ctl_o.ceil_second = (stays == fw);
  assign ctl_o.stays       = stays;
  assign ctl_o.path        = f3_path_q;

endmodule

@@ rtl/ocap_back.sv @@
// Back part: two divisions, bound checks, side and price error checks.
module ocap_back import ocap_pkg::*; #(
  parameter int unsigned A = AMOUNT_BITS_DEF,
  parameter int unsigned P = PRICE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  logic [A+P-1:0] x1_i,
  input  logic [P-1:0]   n_i,
  input  logic [P-1:0]   d_i,
  input  logic [A-1:0]   lim_w_i,
  input  logic [A-1:0]   lim_s_i,
  input  ctl_t           ctl_i,
  output logic           o_push_o,
  input  logic           o_full_i,
  output logic [A-1:0]   wheat_o,
  output logic [A-1:0]   sheep_o,
  output logic           stays_o,
  output logic [ST_W-1:0] status_o
);

  localparam int unsigned CTL_W = $bits(ctl_t);
  localparam int unsigned SB1W  = 2 * P + 2 * A + CTL_W;
  localparam int unsigned SB2W  = A + 1 + SB1W;
  localparam int unsigned IW    = 2 * A + ST_W + 3;
  localparam int unsigned XW    = A + P;
  // positions of the prices inside the sideband
  localparam int unsigned D_POS = CTL_W + 2 * A;
  localparam int unsigned N_POS = D_POS + P;

  logic            be;

  // first division
  logic            dv1_vld, dv1_ovf;
  logic [A-1:0]    dv1_q;
  logic [SB1W-1:0] dv1_sb;
  logic [P-1:0]    s1_n, s1_d;
  ctl_t            s1_ctl;

  // product of the first quotient
  logic [XW-1:0]   mp;
  logic            m1_vld_q, m2_vld_q;
  logic [SB2W-1:0] m1_sb_q, m2_sb_q;
  logic [P-1:0]    m2_n, m2_d;
  ctl_t            m2_ctl;

  // second division
  logic            dv2_vld, dv2_ovf;
  logic [A-1:0]    dv2_q;
  logic [SB2W-1:0] dv2_sb;
  logic [A-1:0]    t_q1, t_lw, t_ls;
  logic            t_ovf1;
  logic [P-1:0]    t_n, t_d;
  ctl_t            t_ctl;
  logic [A-1:0]    c1_w_d, c1_s_d;
  status_e         c1_st_d;

  // check stages
  logic            c1_vld_q, c2_vld_q, c3_vld_q, c4_vld_q, c5_vld_q;
  logic [IW-1:0]   c1_info_q, c2_info_q, c3_info_q, c4_info_q, c5_info_q;
  logic [A-1:0]    c1_w_q, c1_s_q;
  logic [P-1:0]    c1_n_q, c1_d_q;
  logic [XW-1:0]   wv, sv;
  logic [XW-1:0]   c4_diff_q, c4_wv_q, c5_wv_q;
  logic            c4_svgt_q, c4_wvgt_q, c5_svgt_q, c5_wvgt_q;
  logic [XW+PCT_BITS-1:0] c5_diff100_q;

  // final decision
  logic [A-1:0]    f_w, f_s;
  logic [ST_W-1:0] f_st_bits;
  logic            f_nz, f_stays, f_path, f_over, f_keep;
  status_e         f_st;

  // the back holds while its last item waits on a full output queue
  assign be      = !(c5_vld_q && o_full_i);
  assign q_pop_o = be && !q_empty_i;

  ocap_div #(.A(A), .P(P), .SBW(SB1W)) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (be),
    .vld_i  (!q_empty_i),
    .x_i    (x1_i),
    .d_i    (ctl_i.first_wheat ? n_i : d_i),
    .up_i   (1'b0),
    .sb_i   ({n_i, d_i, lim_w_i, lim_s_i, ctl_i}),
    .vld_o  (dv1_vld),
    .q_o    (dv1_q),
    .ovf_o  (dv1_ovf),
    .sb_o   (dv1_sb)
  );

  assign s1_n   = dv1_sb[N_POS +: P];
  assign s1_d   = dv1_sb[D_POS +: P];
  assign s1_ctl = dv1_sb[CTL_W-1:0];

  // first quotient times its own divisor
  ocap_mul #(.A(A), .P(P)) u_mul_q1 (
    .clk_i (clk_i),
    .en_i  (be),
    .a_i   (dv1_q),
    .b_i   (s1_ctl.first_wheat ? s1_n : s1_d),
    .p_o   (mp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (be) begin
      m1_vld_q <= dv1_vld;
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      m1_sb_q <= {dv1_q, dv1_ovf, dv1_sb};
      m2_sb_q <= m1_sb_q;
    end
  end

  assign m2_n   = m2_sb_q[N_POS +: P];
  assign m2_d   = m2_sb_q[D_POS +: P];
  assign m2_ctl = m2_sb_q[CTL_W-1:0];

  ocap_div #(.A(A), .P(P), .SBW(SB2W)) u_div2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (be),
    .vld_i  (m2_vld_q),
    .x_i    (mp),
    .d_i    (m2_ctl.first_wheat ? m2_d : m2_n),
    .up_i   (m2_ctl.ceil_second),
    .sb_i   (m2_sb_q),
    .vld_o  (dv2_vld),
    .q_o    (dv2_q),
    .ovf_o  (dv2_ovf),
    .sb_o   (dv2_sb)
  );

  assign {t_q1, t_ovf1, t_n, t_d, t_lw, t_ls, t_ctl} = dv2_sb;

  // overflow of either division, then wheat and sheep bounds
  always_comb begin
    c1_w_d = t_ctl.first_wheat ? t_q1 : dv2_q;
    c1_s_d = t_ctl.first_wheat ? dv2_q : t_q1;
    if (t_ovf1) begin
      c1_st_d = t_ctl.first_wheat ? ST_WHEAT_OOB : ST_SHEEP_OOB;
    end else if (dv2_ovf) begin
      c1_st_d = t_ctl.first_wheat ? ST_SHEEP_OOB : ST_WHEAT_OOB;
    end else if (c1_w_d > t_lw) begin
      c1_st_d = ST_WHEAT_OOB;
    end else if (c1_s_d > t_ls) begin
      c1_st_d = ST_SHEEP_OOB;
    end else begin
      c1_st_d = ST_OK;
    end
  end

  // trade values at the offer price
  ocap_mul #(.A(A), .P(P)) u_mul_wv (
    .clk_i(clk_i), .en_i(be), .a_i(c1_w_q), .b_i(c1_n_q), .p_o(wv)
  );
  ocap_mul #(.A(A), .P(P)) u_mul_sv (
    .clk_i(clk_i), .en_i(be), .a_i(c1_s_q), .b_i(c1_d_q), .p_o(sv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      c3_vld_q <= 1'b0;
      c4_vld_q <= 1'b0;
      c5_vld_q <= 1'b0;
    end else if (be) begin
      c1_vld_q <= dv2_vld;
      c2_vld_q <= c1_vld_q;
      c3_vld_q <= c2_vld_q;
      c4_vld_q <= c3_vld_q;
      c5_vld_q <= c4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      c1_w_q       <= c1_w_d;
      c1_s_q       <= c1_s_d;
      c1_n_q       <= t_n;
      c1_d_q       <= t_d;
      c1_info_q    <= {c1_w_d, c1_s_d, c1_st_d, (c1_w_d != '0) && (c1_s_d != '0),
                       t_ctl.stays, t_ctl.path};
      c2_info_q    <= c1_info_q;
      c3_info_q    <= c2_info_q;
      // value difference and its hundredfold
      c4_info_q    <= c3_info_q;
      c4_wv_q      <= wv;
      c4_svgt_q    <= (sv > wv);
      c4_wvgt_q    <= (wv > sv);
      c4_diff_q    <= (wv > sv) ? (wv - sv) : (sv - wv);
      c5_info_q    <= c4_info_q;
      c5_wv_q      <= c4_wv_q;
      c5_svgt_q    <= c4_svgt_q;
      c5_wvgt_q    <= c4_wvgt_q;
      c5_diff100_q <= {{PCT_BITS{1'b0}}, c4_diff_q} * (XW + PCT_BITS)'(PRICE_PCT);
    end
  end

  assign {f_w, f_s, f_st_bits, f_nz, f_stays, f_path} = c5_info_q;
  assign f_over = (c5_diff100_q > {{PCT_BITS{1'b0}}, c5_wv_q});

  // favoured side and price error rules
  always_comb begin
    f_st   = status_e'(f_st_bits);
    f_keep = 1'b1;
    if (f_st == ST_OK) begin
      if (!f_nz) begin
        f_keep = 1'b0;
      end else if (f_stays && c5_wvgt_q) begin
        f_st = ST_FAV_SHEEP;
      end else if (!f_stays && c5_svgt_q) begin
        f_st = ST_FAV_WHEAT;
      end else if (!f_path) begin
        if (f_over) begin
          f_keep = 1'b0;
        end
      end else if (!c5_svgt_q && f_over) begin
        f_st = ST_PRICE_ERR;
      end
    end
    if (f_st != ST_OK) begin
      f_keep = 1'b0;
    end
  end

  assign o_push_o = c5_vld_q && !o_full_i;
  assign wheat_o  = f_keep ? f_w : '0;
  assign sheep_o  = f_keep ? f_s : '0;
  assign stays_o  = f_stays;
  assign status_o = f_st;

endmodule

@@ rtl/offer_cross_amounts_with_price_bound.sv @@
// Offer crossing top level: front part, middle queue, back part, result queue.
// Takes one crossing item per clock while full is low and returns one result item
// for each, in order. Most of the pipeline depth lies in the two dividers of the
// back part, each of which resolves one quotient bit per pipeline stage. The
// front part stalls only when the middle queue is full, the back part only when
// the result queue is full. No memory needs clearing after reset.
module offer_cross_amounts_with_price_bound import ocap_pkg::*; #(
  parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEF,
  parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [PRICE_BITS-1:0]  price_num_i,
  input  logic [PRICE_BITS-1:0]  price_den_i,
  input  logic [AMOUNT_BITS-1:0] max_wheat_send_i,
  input  logic [AMOUNT_BITS-1:0] max_wheat_receive_i,
  input  logic [AMOUNT_BITS-1:0] max_sheep_send_i,
  input  logic [AMOUNT_BITS-1:0] max_sheep_receive_i,
  input  logic                   path_payment_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [AMOUNT_BITS-1:0] wheat_received_o,
  output logic [AMOUNT_BITS-1:0] sheep_sent_o,
  output logic                   wheat_offer_stays_o,
  output logic [ST_W-1:0]        status_o
);

  localparam int unsigned A     = AMOUNT_BITS;
  localparam int unsigned P     = PRICE_BITS;
  localparam int unsigned MIDW  = (A + P) + 2 * P + 2 * A + $bits(ctl_t);
  localparam int unsigned OUTW  = 2 * A + 1 + ST_W;

  // front to middle queue
  logic           fq_push, fq_full;
  logic [A+P-1:0] f_x1;
  logic [P-1:0]   f_n, f_d;
  logic [A-1:0]   f_lw, f_ls;
  ctl_t           f_ctl;

  // middle queue to back
  logic            bq_pop, bq_empty;
  logic [MIDW-1:0] bq_data;
  logic [A+P-1:0]  b_x1;
  logic [P-1:0]    b_n, b_d;
  logic [A-1:0]    b_lw, b_ls;
  ctl_t            b_ctl;

  // back to result queue
  logic            o_push, o_full;
  logic [A-1:0]    o_w, o_s;
  logic            o_stays;
  logic [ST_W-1:0] o_st;
  logic [OUTW-1:0] o_data;

  ocap_front #(.A(A), .P(P)) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .vld_i               (push),
    .full_o              (full),
    .price_num_i         (price_num_i),
    .price_den_i         (price_den_i),
    .max_wheat_send_i    (max_wheat_send_i),
    .max_wheat_receive_i (max_wheat_receive_i),
    .max_sheep_send_i    (max_sheep_send_i),
    .max_sheep_receive_i (max_sheep_receive_i),
    .path_payment_i      (path_payment_i),
    .q_push_o            (fq_push),
    .q_full_i            (fq_full),
    .x1_o                (f_x1),
    .n_o                 (f_n),
    .d_o                 (f_d),
    .lim_w_o             (f_lw),
    .lim_s_o             (f_ls),
    .ctl_o               (f_ctl)
  );

  ocap_fifo #(.W(MIDW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  ({f_x1, f_n, f_d, f_lw, f_ls, f_ctl}),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .data_o  (bq_data),
    .empty_o (bq_empty)
  );

  assign {b_x1, b_n, b_d, b_lw, b_ls, b_ctl} = bq_data;

  ocap_back #(.A(A), .P(P)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (bq_empty),
    .q_pop_o   (bq_pop),
    .x1_i      (b_x1),
    .n_i       (b_n),
    .d_i       (b_d),
    .lim_w_i   (b_lw),
    .lim_s_i   (b_ls),
    .ctl_i     (b_ctl),
    .o_push_o  (o_push),
    .o_full_i  (o_full),
    .wheat_o   (o_w),
    .sheep_o   (o_s),
    .stays_o   (o_stays),
    .status_o  (o_st)
  );

  ocap_fifo #(.W(OUTW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  ({o_w, o_s, o_stays, o_st}),
    .full_o  (o_full),
    .pop_i   (pop),
    .data_o  (o_data),
    .empty_o (empty)
  );

  assign {wheat_received_o, sheep_sent_o, wheat_offer_stays_o, status_o} = o_data;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the offer crossing block: directed and random items, queued result checks.
`timescale 1ns / 100ps

module tb;
  import ocap_pkg::*;

  localparam int AB = AMOUNT_BITS_DEF;
  localparam int PB = PRICE_BITS_DEF;
  localparam logic [AB-1:0] AMAX = '1;
  localparam logic [PB-1:0] PMAX = '1;
  localparam int N_RANDOM = 750;

  // One crossing item and its outcome
  typedef struct {
    logic [PB-1:0] num;
    logic [PB-1:0] den;
    logic [AB-1:0] mws;
    logic [AB-1:0] mwr;
    logic [AB-1:0] mss;
    logic [AB-1:0] msr;
    logic          path;
  } cross_t;

  typedef struct {
    logic [AB-1:0] wheat;
    logic [AB-1:0] sheep;
    logic          stays;
    status_e       st;
  } trade_t;

  // Quotient with floor/ceiling; returns 0 on overflow or zero divisor
  function automatic bit quot(logic [127:0] a, logic [63:0] d, bit up,
                              output logic [AB-1:0] q);
    logic [127:0] qq;
    logic [127:0] rr;
    if (d == 0) begin
      q = AMAX;
      return 0;
    end
    qq = a / d;
    rr = a % d;
    if (up && rr != 0) qq = qq + 1;
    if (qq > {65'd0, AMAX}) begin
      q = AMAX;
      return 0;
    end
    q = qq[AB-1:0];
    return 1;
  endfunction

  // 1% price deviation test
  function automatic bit price_within(logic [127:0] n, logic [127:0] d,
                                      logic [127:0] w, logic [127:0] s, bit fav_wheat);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] diff;
    lhs = PRICE_PCT * n * w;
    rhs = PRICE_PCT * d * s;
    if (fav_wheat && rhs > lhs) return 1;
    diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
    return diff <= n * w;
  endfunction

  function automatic trade_t cross_offers(cross_t c);
    trade_t t;
    logic [127:0] n, d, wa, wb, sa, sb, wval, sval, wv, sv;
    logic [AB-1:0] w, s;
    status_e st;
    n = c.num; d = c.den;
    wa = c.mws * n; wb = c.msr * d;
    sa = c.mss * d; sb = c.mwr * n;
    wval = (wa > wb) ? wb : wa;
    sval = (sa > sb) ? sb : sa;
    t.stays = wval > sval;
    w = 0; s = 0; st = ST_OK;
    if (t.stays) begin
      if (n > d || c.path) begin
        if (!quot(sval, n, 0, w)) st = ST_WHEAT_OOB;
        else if (!quot(w * n, d, 1, s)) st = ST_SHEEP_OOB;
      end else begin
        if (!quot(sval, d, 0, s)) st = ST_SHEEP_OOB;
        else if (!quot(s * d, n, 0, w)) st = ST_WHEAT_OOB;
      end
    end else begin
      if (n > d) begin
        if (!quot(wval, n, 0, w)) st = ST_WHEAT_OOB;
        else if (!quot(w * n, d, 0, s)) st = ST_SHEEP_OOB;
      end else begin
        if (!quot(wval, d, 0, s)) st = ST_SHEEP_OOB;
        else if (!quot(s * d, n, 1, w)) st = ST_WHEAT_OOB;
      end
    end
    if (st == ST_OK) begin
      if (w > ((c.mwr < c.mws) ? c.mwr : c.mws)) st = ST_WHEAT_OOB;
      else if (s > ((c.msr < c.mss) ? c.msr : c.mss)) st = ST_SHEEP_OOB;
    end
    if (st == ST_OK) begin
      if (w > 0 && s > 0) begin
        wv = {65'd0, w} * n;
        sv = {65'd0, s} * d;
        if (t.stays && wv > sv) st = ST_FAV_SHEEP;
        else if (!t.stays && sv > wv) st = ST_FAV_WHEAT;
        else if (!c.path) begin
          if (!price_within(n, d, {65'd0, w}, {65'd0, s}, 0)) begin
            w = 0; s = 0;
          end
        end else if (!price_within(n, d, {65'd0, w}, {65'd0, s}, 1)) st = ST_PRICE_ERR;
      end else begin
        w = 0; s = 0;
      end
    end
    if (st != ST_OK) begin
      w = 0; s = 0;
    end
    t.wheat = w; t.sheep = s; t.st = st;
    return t;
  endfunction

  // Scoreboard of pending trades
  class trade_board;
    trade_t pending[$];
    int errors;

    function void note(cross_t c);
      pending.insert(pending.size(), cross_offers(c));
    endfunction

    function void check(trade_t got);
      trade_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item, wheat %0d sheep %0d", $time,
                 got.wheat, got.sheep);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.wheat !== exp.wheat) begin
        $display("%0t: wheat_received expected %0d actual %0d", $time, exp.wheat, got.wheat);
        errors++;
      end
      if (got.sheep !== exp.sheep) begin
        $display("%0t: sheep_sent expected %0d actual %0d", $time, exp.sheep, got.sheep);
        errors++;
      end
      if (got.stays !== exp.stays) begin
        $display("%0t: wheat_offer_stays expected %0b actual %0b", $time, exp.stays, got.stays);
        errors++;
      end
      if (got.st !== exp.st) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic push = 0;
  logic full;
  logic [PB-1:0] price_num_i = 0, price_den_i = 0;
  logic [AB-1:0] max_wheat_send_i = 0, max_wheat_receive_i = 0;
  logic [AB-1:0] max_sheep_send_i = 0, max_sheep_receive_i = 0;
  logic path_payment_i = 0;
  logic empty;
  logic pop = 0;
  logic [AB-1:0] wheat_received_o, sheep_sent_o;
  logic wheat_offer_stays_o;
  logic [ST_W-1:0] status_o;

  trade_board board = new();
  bit send_done = 0;
  bit calm = 0;
  bit hold_go = 0;
  bit hold_rx = 0;

  offer_cross_amounts_with_price_bound u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .price_num_i(price_num_i), .price_den_i(price_den_i),
    .max_wheat_send_i(max_wheat_send_i), .max_wheat_receive_i(max_wheat_receive_i),
    .max_sheep_send_i(max_sheep_send_i), .max_sheep_receive_i(max_sheep_receive_i),
    .path_payment_i(path_payment_i), .empty(empty), .pop(pop),
    .wheat_received_o(wheat_received_o), .sheep_sent_o(sheep_sent_o),
    .wheat_offer_stays_o(wheat_offer_stays_o), .status_o(status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Random amount: mostly modest, sometimes full width or extreme
  function automatic logic [AB-1:0] rand_amount();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom} & AMAX;
      1: return $urandom_range(0, 3) == 0 ? AMAX : 0;
      2: return $urandom_range(0, 1000);
      3: return AMAX - $urandom_range(0, 1000);
      default: return {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
  endfunction

  function automatic logic [PB-1:0] rand_price();
    case ($urandom_range(0, 3))
      0: return $urandom & PMAX;
      1: return $urandom_range(1, 20);
      2: return PMAX - $urandom_range(0, 5);
      default: return ($urandom & PMAX) >> $urandom_range(0, 30) | 1;
    endcase
  endfunction

  // Offer one item; held until accepted, push stays up for a following item
  task automatic send_item(cross_t c);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1;
    price_num_i <= c.num; price_den_i <= c.den;
    max_wheat_send_i <= c.mws; max_wheat_receive_i <= c.mwr;
    max_sheep_send_i <= c.mss; max_sheep_receive_i <= c.msr;
    path_payment_i <= c.path;
    do @(posedge clk_i); while (full);
    board.note(c);
    @(negedge clk_i);
  endtask

  function automatic cross_t mk(logic [PB-1:0] n, logic [PB-1:0] d, logic [AB-1:0] a,
                                logic [AB-1:0] b, logic [AB-1:0] e, logic [AB-1:0] f,
                                logic p);
    cross_t c;
    c.num = n; c.den = d; c.mws = a; c.mwr = b; c.mss = e; c.msr = f; c.path = p;
    return c;
  endfunction

  // Stimulus
  initial begin
    cross_t c;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: extremes, empty trades, both sides staying, path payments
    send_item(mk(1, 1, 0, 0, 0, 0, 0));
    send_item(mk(1, 1, 100, 100, 100, 100, 0));
    send_item(mk(PMAX, PMAX, AMAX, AMAX, AMAX, AMAX, 0));
    send_item(mk(PMAX, PMAX, AMAX, AMAX, AMAX, AMAX, 1));
    send_item(mk(PMAX, 1, AMAX, AMAX, AMAX, AMAX, 0));
    send_item(mk(1, PMAX, AMAX, AMAX, AMAX, AMAX, 1));
    send_item(mk(3, 7, 1000, 50, 1000, 1000, 0));
    send_item(mk(3, 7, 50, 1000, 1000, 1000, 1));
    send_item(mk(7, 3, 1000, 1000, 10, 1000, 0));
    send_item(mk(7, 3, 1000, 1000, 10, 1000, 1));
    send_item(mk(2, 3, 1, 1, 1, 1, 0));
    send_item(mk(2, 3, 1, 1, 1, 1, 1));
    send_item(mk(3, 2, 1, 1, 1, 1, 0));
    send_item(mk(3, 2, 1, 1, 1, 1, 1));
    send_item(mk(101, 100, 7, 9, 8, 6, 1));
    send_item(mk(99, 100, 7, 9, 8, 6, 0));
    send_item(mk(1, 1, AMAX, 0, AMAX, AMAX, 0));
    send_item(mk(1, 1, AMAX, AMAX, 0, AMAX, 1));
    send_item(mk(PMAX, 1, 1, AMAX, AMAX, 1, 0));
    send_item(mk(1, PMAX, AMAX, 1, 1, AMAX, 1));
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) calm = 1;
      if (i == 200) hold_go = 1;
      c.num = rand_price(); c.den = rand_price();
      c.mws = rand_amount(); c.mwr = rand_amount();
      c.mss = rand_amount(); c.msr = rand_amount();
      c.path = $urandom_range(0, 1);
      send_item(c);
    end
    push <= 0;
    send_done = 1;
  end

  // Long receiver hold-off so the block fills and raises full
  initial begin
    wait (hold_go);
    hold_rx = 1;
    repeat (400) @(negedge clk_i);
    hold_rx = 0;
  end

  // Receiver: random stalls, sampling on the rising edge
  initial begin
    trade_t got;
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        pop <= 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 0;
        gap = $urandom_range(1, 8);
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        pop <= 1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        got.wheat = wheat_received_o; got.sheep = sheep_sent_o;
        got.stays = wheat_offer_stays_o; got.st = status_e'(status_o);
        board.check(got);
      end
    end
  end

  // End of run
  initial begin
    wait (send_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end
endmodule
